// ===== rtl/core/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, token kinds, character codes and decode helpers for the
// source byte tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

  // saturation limit of the token length counter
  localparam logic [15:0] MAX_TOKEN_LEN = 16'hFFFF;

  // packed width of the output stream word
  localparam int unsigned TDATA_W = 56;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_OP,
    MODE_COMMENT,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_STRING,
    MODE_ERROR
  } mode_t;

  // token kinds
  localparam logic [5:0] KIND_LPAREN   = 6'd0;
  localparam logic [5:0] KIND_RPAREN   = 6'd1;
  localparam logic [5:0] KIND_LBRACE   = 6'd2;
  localparam logic [5:0] KIND_RBRACE   = 6'd3;
  localparam logic [5:0] KIND_COMMA    = 6'd4;
  localparam logic [5:0] KIND_DOT      = 6'd5;
  localparam logic [5:0] KIND_MINUS    = 6'd6;
  localparam logic [5:0] KIND_PLUS     = 6'd7;
  localparam logic [5:0] KIND_SEMI     = 6'd8;
  localparam logic [5:0] KIND_COLON    = 6'd9;
  localparam logic [5:0] KIND_STAR     = 6'd10;
  localparam logic [5:0] KIND_BANG     = 6'd11;
  localparam logic [5:0] KIND_BANG_EQ  = 6'd12;
  localparam logic [5:0] KIND_EQ       = 6'd13;
  localparam logic [5:0] KIND_EQ_EQ    = 6'd14;
  localparam logic [5:0] KIND_LT       = 6'd15;
  localparam logic [5:0] KIND_LT_EQ    = 6'd16;
  localparam logic [5:0] KIND_AMP      = 6'd17;
  localparam logic [5:0] KIND_QUEST    = 6'd18;
  localparam logic [5:0] KIND_HASH     = 6'd19;
  localparam logic [5:0] KIND_GT       = 6'd20;
  localparam logic [5:0] KIND_GT_EQ    = 6'd21;
  localparam logic [5:0] KIND_PERCENT  = 6'd22;
  localparam logic [5:0] KIND_SLASH    = 6'd23;
  localparam logic [5:0] KIND_STRING   = 6'd24;
  localparam logic [5:0] KIND_NUMBER   = 6'd25;
  localparam logic [5:0] KIND_IDENT    = 6'd26;
  localparam logic [5:0] KIND_KW_IF    = 6'd27;
  localparam logic [5:0] KIND_KW_FOR   = 6'd28;
  localparam logic [5:0] KIND_KW_WHILE = 6'd29;
  localparam logic [5:0] KIND_KW_CLASS = 6'd30;
  localparam logic [5:0] KIND_KW_CONST = 6'd31;
  localparam logic [5:0] KIND_KW_OR    = 6'd32;
  localparam logic [5:0] KIND_KW_AND   = 6'd33;
  localparam logic [5:0] KIND_ERROR    = 6'd34;

  // character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // keyword spellings, first byte in the high end
  localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
  localparam logic [39:0] KW_FOR   = 40'h00_0066_6F72;
  localparam logic [39:0] KW_WHILE = 40'h77_6869_6C65;
  localparam logic [39:0] KW_CLASS = 40'h63_6C61_7373;
  localparam logic [39:0] KW_CONST = 40'h63_6F6E_7374;
  localparam logic [39:0] KW_OR    = 40'h00_0000_6F72;
  localparam logic [39:0] KW_AND   = 40'h00_0061_6E64;

  // one emitted token
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] length;
    logic        last;
  } token_t;

  // tokens produced by the scanner for the current byte
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_out_t;

  // single-character token lookup result
  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
  } single_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic single_t single_kind(input logic [7:0] c);
    single_t s;
    s.hit  = 1'b1;
    s.kind = KIND_LPAREN;
    case (c)
      CH_LPAREN:  s.kind = KIND_LPAREN;
      CH_RPAREN:  s.kind = KIND_RPAREN;
      CH_LBRACE:  s.kind = KIND_LBRACE;
      CH_RBRACE:  s.kind = KIND_RBRACE;
      CH_COMMA:   s.kind = KIND_COMMA;
      CH_DOT:     s.kind = KIND_DOT;
      CH_MINUS:   s.kind = KIND_MINUS;
      CH_PLUS:    s.kind = KIND_PLUS;
      CH_SEMI:    s.kind = KIND_SEMI;
      CH_COLON:   s.kind = KIND_COLON;
      CH_STAR:    s.kind = KIND_STAR;
      CH_AMP:     s.kind = KIND_AMP;
      CH_QUEST:   s.kind = KIND_QUEST;
      CH_HASH:    s.kind = KIND_HASH;
      CH_PERCENT: s.kind = KIND_PERCENT;
      default:    s.hit  = 1'b0;
    endcase
    single_kind = s;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c, input logic with_eq);
    case (c)
      CH_BANG: op_kind = with_eq ? KIND_BANG_EQ : KIND_BANG;
      CH_EQ:   op_kind = with_eq ? KIND_EQ_EQ : KIND_EQ;
      CH_LT:   op_kind = with_eq ? KIND_LT_EQ : KIND_LT;
      CH_GT:   op_kind = with_eq ? KIND_GT_EQ : KIND_GT;
      default: op_kind = KIND_SLASH;
    endcase
  endfunction

  // keyword only on an exact, full-length match
  function automatic logic [5:0] ident_kind(input logic [39:0] prefix,
                                            input logic [15:0] len);
    if (len == 16'd2 && prefix == KW_IF) begin
      ident_kind = KIND_KW_IF;
    end else if (len == 16'd3 && prefix == KW_FOR) begin
      ident_kind = KIND_KW_FOR;
    end else if (len == 16'd5 && prefix == KW_WHILE) begin
      ident_kind = KIND_KW_WHILE;
    end else if (len == 16'd5 && prefix == KW_CLASS) begin
      ident_kind = KIND_KW_CLASS;
    end else if (len == 16'd5 && prefix == KW_CONST) begin
      ident_kind = KIND_KW_CONST;
    end else if (len == 16'd2 && prefix == KW_OR) begin
      ident_kind = KIND_KW_OR;
    end else if (len == 16'd3 && prefix == KW_AND) begin
      ident_kind = KIND_KW_AND;
    end else begin
      ident_kind = KIND_IDENT;
    end
  endfunction

endpackage

// ===== rtl/core/sbt_scan.sv =====
// ----------------------------------------------------------------------------
// sbt_scan
// Scanner state and the single-pass decode of one source byte into up to
// two tokens; state advances when step is high.
// ----------------------------------------------------------------------------
module sbt_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               at_end,
  input  logic               step,
  output sbt_pkg::scan_out_t scan_out
);
  import sbt_pkg::*;

  mode_t       mode, mode_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic        seen_dot, seen_dot_next;
  logic [39:0] word_prefix, word_prefix_next;
  logic [15:0] token_line, token_line_next;
  logic [15:0] token_column, token_column_next;
  logic [15:0] token_length, token_length_next;
  logic [15:0] line_count, line_count_next;
  logic [15:0] column_count, column_count_next;

  logic        c_digit, c_letter, c_word, c_op, c_space, c_quote, c_nl, c_dot;
  logic        c_bad;
  single_t     c_single;
  mode_t       idle_mode;
  logic [15:0] len_grown;

  logic        rescan;
  logic        p1_emit;
  logic [5:0]  p1_kind;
  logic [15:0] p1_len;
  logic        p2_emit;
  logic [5:0]  p2_kind;
  token_t      t1, t2;

  // byte class decode
  assign c_digit  = is_digit(ch);
  assign c_letter = is_letter(ch);
  assign c_word   = c_digit || c_letter || (ch == CH_UNDER);
  assign c_single = single_kind(ch);
  assign c_op     = (ch == CH_BANG) || (ch == CH_EQ) || (ch == CH_LT) ||
                    (ch == CH_GT) || (ch == CH_SLASH);
  assign c_space  = (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_TAB) || (ch == CH_NL);
  assign c_quote  = (ch == CH_QUOTE);
  assign c_nl     = (ch == CH_NL);
  assign c_dot    = (ch == CH_DOT);
  assign c_bad    = !(c_single.hit || c_op || c_space || c_quote || c_digit || c_letter);

  assign len_grown = (token_length < MAX_TOKEN_LEN) ? token_length + 16'd1 : token_length;

  // mode entered when a byte starts a fresh token
  always_comb begin
    if (c_single.hit || c_space) begin
      idle_mode = MODE_IDLE;
    end else if (c_op) begin
      idle_mode = MODE_OP;
    end else if (c_quote) begin
      idle_mode = MODE_STRING;
    end else if (c_digit) begin
      idle_mode = MODE_NUMBER;
    end else if (c_letter) begin
      idle_mode = MODE_IDENT;
    end else begin
      idle_mode = MODE_ERROR;
    end
  end

  // tokens closed by this byte, and whether the byte is scanned afresh
  always_comb begin
    p1_emit = 1'b0;
    p1_kind = KIND_ERROR;
    p1_len  = 16'd0;
    rescan  = 1'b0;
    if (at_end) begin
      unique case (mode)
        MODE_OP: begin
          p1_emit = 1'b1;
          p1_kind = op_kind(pending_byte, 1'b0);
          p1_len  = 16'd1;
        end
        MODE_NUMBER: begin
          p1_emit = 1'b1;
          p1_kind = KIND_NUMBER;
          p1_len  = token_length;
        end
        MODE_IDENT: begin
          p1_emit = 1'b1;
          p1_kind = ident_kind(word_prefix, token_length);
          p1_len  = token_length;
        end
        MODE_STRING: begin
          p1_emit = 1'b1;
          p1_kind = KIND_STRING;
          p1_len  = token_length;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          rescan = 1'b1;
        end
        MODE_OP: begin
          if (pending_byte == CH_SLASH && ch == CH_SLASH) begin
            p1_emit = 1'b0;
          end else if (pending_byte != CH_SLASH && ch == CH_EQ) begin
            p1_emit = 1'b1;
            p1_kind = op_kind(pending_byte, 1'b1);
            p1_len  = 16'd2;
          end else begin
            p1_emit = 1'b1;
            p1_kind = op_kind(pending_byte, 1'b0);
            p1_len  = 16'd1;
            rescan  = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (!(c_digit || (c_dot && !seen_dot))) begin
            p1_emit = 1'b1;
            p1_kind = KIND_NUMBER;
            p1_len  = token_length;
            rescan  = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (!c_word) begin
            p1_emit = 1'b1;
            p1_kind = ident_kind(word_prefix, token_length);
            p1_len  = token_length;
            rescan  = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c_quote) begin
            p1_emit = 1'b1;
            p1_kind = KIND_STRING;
            p1_len  = len_grown;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next mode
  always_comb begin
    mode_next = mode;
    if (mode == MODE_ERROR) begin
      mode_next = MODE_ERROR;
    end else if (at_end) begin
      mode_next = MODE_IDLE;
    end else if (rescan) begin
      mode_next = idle_mode;
    end else begin
      unique case (mode)
        MODE_OP:      mode_next = (ch == CH_SLASH) ? MODE_COMMENT : MODE_IDLE;
        MODE_COMMENT: mode_next = c_nl ? MODE_IDLE : MODE_COMMENT;
        MODE_STRING:  mode_next = c_quote ? MODE_IDLE : MODE_STRING;
        default:      mode_next = mode;
      endcase
    end
  end

  // token outputs
  always_comb begin
    p2_emit = rescan && (c_single.hit || c_bad);
    p2_kind = c_single.hit ? c_single.kind : KIND_ERROR;
    t1 = '{kind: p1_kind, start_line: token_line, start_column: token_column,
           length: p1_len, last: !p2_emit};
    t2 = '{kind: p2_kind, start_line: line_count, start_column: column_count,
           length: 16'd1, last: 1'b1};
    scan_out.count = {1'b0, p1_emit} + {1'b0, p2_emit};
    scan_out.tok0  = p1_emit ? t1 : t2;
    scan_out.tok1  = t2;
  end

  // token bookkeeping and source position
  always_comb begin
    pending_byte_next = pending_byte;
    seen_dot_next     = seen_dot;
    word_prefix_next  = word_prefix;
    token_line_next   = token_line;
    token_column_next = token_column;
    token_length_next = token_length;
    line_count_next   = line_count;
    column_count_next = column_count;
    if (!at_end && mode != MODE_ERROR) begin
      if (rescan) begin
        token_line_next   = line_count;
        token_column_next = column_count;
        token_length_next = 16'd1;
        if (c_op) begin
          pending_byte_next = ch;
        end
        if (c_digit) begin
          seen_dot_next = 1'b0;
        end
        if (c_letter) begin
          word_prefix_next = {32'd0, ch};
        end
      end else if (mode == MODE_NUMBER) begin
        token_length_next = len_grown;
        if (c_dot) begin
          seen_dot_next = 1'b1;
        end
      end else if (mode == MODE_IDENT) begin
        token_length_next = len_grown;
        if (token_length < 16'd5) begin
          word_prefix_next = {word_prefix[31:0], ch};
        end
      end else if (mode == MODE_STRING) begin
        token_length_next = len_grown;
      end
      if (c_nl) begin
        line_count_next   = sat_inc16(line_count);
        column_count_next = 16'd0;
      end else begin
        column_count_next = sat_inc16(column_count);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      pending_byte <= 8'd0;
      seen_dot     <= 1'b0;
      word_prefix  <= 40'd0;
      token_line   <= 16'd0;
      token_column <= 16'd0;
      token_length <= 16'd0;
      line_count   <= 16'd0;
      column_count <= 16'd0;
    end else if (step) begin
      mode         <= mode_next;
      pending_byte <= pending_byte_next;
      seen_dot     <= seen_dot_next;
      word_prefix  <= word_prefix_next;
      token_line   <= token_line_next;
      token_column <= token_column_next;
      token_length <= token_length_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
    end
  end

endmodule

// ===== rtl/core/sbt_out_buf.sv =====
// ----------------------------------------------------------------------------
// sbt_out_buf
// Two-entry token buffer: output register plus one skid slot, taking up to
// two tokens per cycle and presenting one.
// ----------------------------------------------------------------------------
module sbt_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  sbt_pkg::token_t tok0,
  input  sbt_pkg::token_t tok1,
  input  logic            out_ready,
  output logic            out_valid,
  output sbt_pkg::token_t head,
  output logic [1:0]      free_slots
);
  import sbt_pkg::*;

  logic [1:0] count, count_next;
  logic [1:0] remain;
  logic       pop;
  token_t     slot [2];
  token_t     slot_next [2];

  // occupancy after this cycle's pop
  assign pop        = (count != 2'd0) && out_ready;
  assign remain     = count - {1'b0, pop};
  assign free_slots = 2'd2 - remain;
  assign count_next = remain + push_count;
  assign out_valid  = (count != 2'd0);
  assign head       = slot[0];

  // shift the survivor down and append new tokens behind it
  always_comb begin
    slot_next[0] = slot[0];
    slot_next[1] = slot[1];
    case (remain)
      2'd0: begin
        slot_next[0] = tok0;
        slot_next[1] = tok1;
      end
      2'd1: begin
        slot_next[0] = pop ? slot[1] : slot[0];
        slot_next[1] = tok0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
  end

endmodule

// ===== rtl/core/source_byte_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// source_byte_tokenizer_core
// Streaming lexical scanner: one source byte or end marker per word in,
// tokens with kind, start line, start column and length out.
// ----------------------------------------------------------------------------
// path: a byte is held in the input register, and its tokens in the token buffer, before they reach the output
// throughput: one byte per cycle; a byte waits in the input register only
//   while the two-entry token buffer lacks room for the tokens it produces
// reset: synchronous rst empties input register and token buffer and returns
//   the scanner to idle at line 0, column 0; no clearing pass is needed
module source_byte_tokenizer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // ch[7:0]
  input  logic                       s_axis_tuser,  // at_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [sbt_pkg::TDATA_W-1:0] m_axis_tdata, // kind[5:0], start_line[21:6],
                                                    // start_column[37:22],
                                                    // length[53:38], zero[55:54]
  output logic                       m_axis_tlast
);
  import sbt_pkg::*;

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_end;
  logic       fire;
  logic [1:0] free_slots;
  logic [1:0] push_count;
  scan_out_t  scan_out;
  token_t     head;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch  <= s_axis_tdata;
      in_end <= s_axis_tuser;
    end
  end

  // the held byte is scanned once the buffer has room for its tokens
  assign fire          = in_valid && (scan_out.count <= free_slots);
  assign s_axis_tready = !in_valid || fire;
  assign push_count    = fire ? scan_out.count : 2'd0;

  sbt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .ch       (in_ch),
    .at_end   (in_end),
    .step     (fire),
    .scan_out (scan_out)
  );

  sbt_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .tok0       (scan_out.tok0),
    .tok1       (scan_out.tok1),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .head       (head),
    .free_slots (free_slots)
  );

  // output word packing
  assign m_axis_tdata = {2'b00, head.length, head.start_column, head.start_line, head.kind};
  assign m_axis_tlast = head.last;

endmodule

// ===== rtl/core/sbt_checker.sv =====
// ----------------------------------------------------------------------------
// sbt_checker
// Port-level checks on the tokenizer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module sbt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [7:0]                  s_axis_tdata,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [sbt_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);
  import sbt_pkg::*;

  logic [5:0]  out_kind;
  logic [15:0] out_len;
  logic        in_seen;

  assign out_kind = m_axis_tdata[5:0];
  assign out_len  = m_axis_tdata[53:38];
  assign in_seen  = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'd0 || s_axis_tuser);

  // stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled token changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("token valid after reset");

  // kinds stay within the defined range
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_kind <= KIND_ERROR)
    else $error("token kind out of range");

  // an error token is one byte long and ends its item
  a_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_kind == KIND_ERROR |-> m_axis_tlast && out_len == 16'd1)
    else $error("malformed error token");

  // two-character operators are two bytes long
  a_pair: assert property (@(posedge clk) disable iff (rst || in_seen && 1'b0)
    m_axis_tvalid && (out_kind == KIND_BANG_EQ || out_kind == KIND_EQ_EQ ||
                      out_kind == KIND_LT_EQ || out_kind == KIND_GT_EQ)
      |-> out_len == 16'd2)
    else $error("two-character operator with wrong length");

endmodule

bind source_byte_tokenizer_core sbt_checker u_sbt_checker (.*);
